FILE: design/assert_macros.svh
// Assertion macros used by the RTL files that include them.
// Included by files that check their own logic; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/dpct_pkg.sv
// Types and constants for the disk pair collision time core.
// No dependencies.
package dpct_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [1:0] {
        ST_TIME     = 2'd0,
        ST_SEPARATE = 2'd1,
        ST_MISS     = 2'd2,
        ST_OVERLAP  = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_pos_x;
        logic signed [COORD_WIDTH-1:0] a_pos_y;
        logic signed [COORD_WIDTH-1:0] a_vel_x;
        logic signed [COORD_WIDTH-1:0] a_vel_y;
        logic        [COORD_WIDTH-2:0] a_radius;
        logic signed [COORD_WIDTH-1:0] b_pos_x;
        logic signed [COORD_WIDTH-1:0] b_pos_y;
        logic signed [COORD_WIDTH-1:0] b_vel_x;
        logic signed [COORD_WIDTH-1:0] b_vel_y;
        logic        [COORD_WIDTH-2:0] b_radius;
    } t_in_item;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] contact_time;
        t_status                contact_status;
    } t_out_item;

endpackage

FILE: design/disk_pair_collision_time_core.sv
// Disk pair collision time: fully pipelined, one item per cycle while the output is taken.
// Depends on dpct_pkg and assert_macros.svh.
//
//  channel | direction | handshake                  | payload
//  in      | into core | i_in_valid / o_in_ready    | i_in_item  (dpct_pkg::t_in_item)
//  out     | from core | o_out_valid / i_out_ready  | o_out_item (dpct_pkg::t_out_item)
//
// The pipeline has six arithmetic stages, one stage per root bit of the square root,
// two stages for the denominator and the saturation compare, one stage per quotient
// bit, and the output register.
// Throughput is one item per cycle. Reset clears only the valid bits.
// When the output register is full and not taken, the whole pipeline holds.
`include "assert_macros.svh"

module disk_pair_collision_time_core #(
    parameter int FRAC_BITS = dpct_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dpct_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dpct_pkg::t_out_item  o_out_item
);

    localparam int CW   = dpct_pkg::COORD_WIDTH;
    localparam int DW   = CW + 1;           // coordinate difference
    localparam int PW   = 2 * DW;           // product of differences
    localparam int VW   = 2 * CW + 3;       // v.r and gap, signed
    localparam int MW   = 2 * CW + 2;       // magnitudes of v.r, q, |v|^2
    localparam int HW   = CW + 1;           // half of MW
    localparam int SQW  = 2 * MW;           // full products
    localparam int DETW = SQW + 1;
    localparam int RTW  = MW;               // root bits
    localparam int REMW = RTW + 2;
    localparam int DENW = RTW + 1;
    localparam int NUMW = MW + FRAC_BITS;
    localparam int CMPW = (NUMW > DENW + CW) ? NUMW : DENW + CW;
    localparam int DRW  = ((DENW > NUMW - CW) ? DENW : NUMW - CW) + 1;

    logic w_en;
    logic r_out_valid;
    dpct_pkg::t_out_item r_out_item;

    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // stage 1: differences and radius sum
    logic                 r1_v;
    logic signed [DW-1:0] r1_rx, r1_ry, r1_vx, r1_vy;
    logic        [CW-1:0] r1_rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_rx <= $signed({i_in_item.a_pos_x[CW-1], i_in_item.a_pos_x})
                   - $signed({i_in_item.b_pos_x[CW-1], i_in_item.b_pos_x});
            r1_ry <= $signed({i_in_item.a_pos_y[CW-1], i_in_item.a_pos_y})
                   - $signed({i_in_item.b_pos_y[CW-1], i_in_item.b_pos_y});
            r1_vx <= $signed({i_in_item.a_vel_x[CW-1], i_in_item.a_vel_x})
                   - $signed({i_in_item.b_vel_x[CW-1], i_in_item.b_vel_x});
            r1_vy <= $signed({i_in_item.a_vel_y[CW-1], i_in_item.a_vel_y})
                   - $signed({i_in_item.b_vel_y[CW-1], i_in_item.b_vel_y});
            r1_rs <= {1'b0, i_in_item.a_radius} + {1'b0, i_in_item.b_radius};
        end
    end

    // stage 2: seven products
    logic                 r2_v;
    logic signed [PW-1:0] r2_rxvx, r2_ryvy, r2_rxrx, r2_ryry, r2_vxvx, r2_vyvy;
    logic      [2*CW-1:0] r2_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_rxvx <= r1_rx * r1_vx;
            r2_ryvy <= r1_ry * r1_vy;
            r2_rxrx <= r1_rx * r1_rx;
            r2_ryry <= r1_ry * r1_ry;
            r2_vxvx <= r1_vx * r1_vx;
            r2_vyvy <= r1_vy * r1_vy;
            r2_rr   <= r1_rs * r1_rs;
        end
    end

    // stage 3: v.r, gap q, |v|^2 and the first two outcomes
    logic               r3_v;
    logic [VW-1:0]      r3_vdr, r3_q;
    logic [MW-1:0]      r3_vsq;
    logic               r3_done;
    dpct_pkg::t_status  r3_st;
    logic [VW-1:0]      n3_vdr, n3_q;

    assign n3_vdr = {r2_rxvx[PW-1], r2_rxvx} + {r2_ryvy[PW-1], r2_ryvy};
    assign n3_q   = {1'b0, r2_rxrx} + {1'b0, r2_ryry} - {3'b000, r2_rr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_vdr <= n3_vdr;
            r3_q   <= n3_q;
            r3_vsq <= $unsigned(r2_vxvx) + $unsigned(r2_vyvy);
            priority if (!n3_vdr[VW-1] && (n3_vdr != '0)) begin
                r3_done <= 1'b1;
                r3_st   <= dpct_pkg::ST_SEPARATE;
            end else if (n3_q[VW-1]) begin
                r3_done <= 1'b1;
                r3_st   <= dpct_pkg::ST_OVERLAP;
            end else begin
                r3_done <= 1'b0;
                r3_st   <= dpct_pkg::ST_TIME;
            end
        end
    end

    // stage 4: partial products of (v.r)^2 and |v|^2 * q
    logic               r4_v;
    logic [MW-1:0]      r4_ahh, r4_ahl, r4_all;
    logic [MW-1:0]      r4_bhh, r4_bhl, r4_blh, r4_bll;
    logic [MW-1:0]      r4_vmag, r4_q;
    logic               r4_done;
    dpct_pkg::t_status  r4_st;
    logic [VW-1:0]      n4_vneg;
    logic [MW-1:0]      n4_vmag, n4_qm;

    // where v.r is not positive its magnitude is its negation; positive v.r is already done
    assign n4_vneg = ~r3_vdr + 1'b1;
    assign n4_vmag = n4_vneg[MW-1:0];
    assign n4_qm   = r3_q[MW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ahh  <= n4_vmag[MW-1:HW] * n4_vmag[MW-1:HW];
            r4_ahl  <= n4_vmag[MW-1:HW] * n4_vmag[HW-1:0];
            r4_all  <= n4_vmag[HW-1:0]  * n4_vmag[HW-1:0];
            r4_bhh  <= r3_vsq[MW-1:HW]  * n4_qm[MW-1:HW];
            r4_bhl  <= r3_vsq[MW-1:HW]  * n4_qm[HW-1:0];
            r4_blh  <= r3_vsq[HW-1:0]   * n4_qm[MW-1:HW];
            r4_bll  <= r3_vsq[HW-1:0]   * n4_qm[HW-1:0];
            r4_vmag <= n4_vmag;
            r4_q    <= n4_qm;
            r4_done <= r3_done;
            r4_st   <= r3_st;
        end
    end

    // stage 5: assemble the two full products
    logic               r5_v;
    logic [SQW-1:0]     r5_vdr2, r5_vq;
    logic [MW-1:0]      r5_vmag, r5_q;
    logic               r5_done;
    dpct_pkg::t_status  r5_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_vdr2 <= {r4_ahh, r4_all} + (SQW'(r4_ahl) << (HW + 1));
            r5_vq   <= {r4_bhh, r4_bll} + (SQW'(r4_bhl) << HW) + (SQW'(r4_blh) << HW);
            r5_vmag <= r4_vmag;
            r5_q    <= r4_q;
            r5_done <= r4_done;
            r5_st   <= r4_st;
        end
    end

    // stage 6 and square root pipeline, one root bit per stage
    logic               r_sq_v    [0:RTW];
    logic [SQW-1:0]     r_sq_det  [0:RTW];
    logic [REMW-1:0]    r_sq_rem  [0:RTW];
    logic [RTW-1:0]     r_sq_root [0:RTW];
    logic [MW-1:0]      r_sq_vmag [0:RTW];
    logic [MW-1:0]      r_sq_q    [0:RTW];
    logic               r_sq_done [0:RTW];
    dpct_pkg::t_status  r_sq_st   [0:RTW];
    logic [DETW-1:0]    n6_det;

    assign n6_det = {1'b0, r5_vdr2} - {1'b0, r5_vq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_v[0] <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_det[0]  <= n6_det[SQW-1:0];
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_vmag[0] <= r5_vmag;
            r_sq_q[0]    <= r5_q;
            if (!r5_done && n6_det[DETW-1]) begin
                r_sq_done[0] <= 1'b1;
                r_sq_st[0]   <= dpct_pkg::ST_MISS;
            end else begin
                r_sq_done[0] <= r5_done;
                r_sq_st[0]   <= r5_st;
            end
        end
    end

    for (genvar k = 0; k < RTW; k++) begin : g_sqrt
        logic [REMW-1:0] n_rem_sh, n_trial;
        logic            n_take;

        assign n_rem_sh = {r_sq_rem[k][REMW-3:0], r_sq_det[k][SQW-1-2*k -: 2]};
        assign n_trial  = {r_sq_root[k], 2'b01};
        assign n_take   = (n_rem_sh >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[k+1]  <= n_take ? (n_rem_sh - n_trial) : n_rem_sh;
                r_sq_root[k+1] <= {r_sq_root[k][RTW-2:0], n_take};
                r_sq_det[k+1]  <= r_sq_det[k];
                r_sq_vmag[k+1] <= r_sq_vmag[k];
                r_sq_q[k+1]    <= r_sq_q[k];
                r_sq_done[k+1] <= r_sq_done[k];
                r_sq_st[k+1]   <= r_sq_st[k];
            end
        end
    end

    // denominator: root + |v.r|, and a miss when it is zero
    logic               r_dn_v;
    logic [DENW-1:0]    r_dn_den;
    logic [MW-1:0]      r_dn_q;
    logic               r_dn_done;
    dpct_pkg::t_status  r_dn_st;
    logic [DENW-1:0]    n_dn_den;

    assign n_dn_den = {1'b0, r_sq_root[RTW]} + {1'b0, r_sq_vmag[RTW]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dn_v <= 1'b0;
        end else if (w_en) begin
            r_dn_v <= r_sq_v[RTW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dn_den <= n_dn_den;
            r_dn_q   <= r_sq_q[RTW];
            if (!r_sq_done[RTW] && (n_dn_den == '0)) begin
                r_dn_done <= 1'b1;
                r_dn_st   <= dpct_pkg::ST_MISS;
            end else begin
                r_dn_done <= r_sq_done[RTW];
                r_dn_st   <= r_sq_st[RTW];
            end
        end
    end

    // saturation compare and long division, one quotient bit per stage
    logic               r_dv_v    [0:CW];
    logic [DRW-1:0]     r_dv_rem  [0:CW];
    logic [CW-1:0]      r_dv_quo  [0:CW];
    logic [CW-1:0]      r_dv_lo   [0:CW];
    logic [DENW-1:0]    r_dv_den  [0:CW];
    logic               r_dv_sat  [0:CW];
    logic               r_dv_done [0:CW];
    dpct_pkg::t_status  r_dv_st   [0:CW];
    logic [NUMW-1:0]    n_dv_num;

    assign n_dv_num = {r_dn_q, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_v[0] <= r_dn_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // quotient fits CW bits exactly when num < den * 2^CW
            r_dv_sat[0]  <= CMPW'(n_dv_num) >= CMPW'({r_dn_den, {CW{1'b0}}});
            r_dv_rem[0]  <= DRW'(n_dv_num[NUMW-1:CW]);
            r_dv_lo[0]   <= n_dv_num[CW-1:0];
            r_dv_quo[0]  <= '0;
            r_dv_den[0]  <= r_dn_den;
            r_dv_done[0] <= r_dn_done;
            r_dv_st[0]   <= r_dn_st;
        end
    end

    for (genvar j = 0; j < CW; j++) begin : g_div
        logic [DRW-1:0] n_rem_sh;
        logic           n_take;

        assign n_rem_sh = {r_dv_rem[j][DRW-2:0], r_dv_lo[j][CW-1-j]};
        assign n_take   = (n_rem_sh >= DRW'(r_dv_den[j]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[j+1]  <= n_take ? (n_rem_sh - DRW'(r_dv_den[j])) : n_rem_sh;
                r_dv_quo[j+1]  <= {r_dv_quo[j][CW-2:0], n_take};
                r_dv_lo[j+1]   <= r_dv_lo[j];
                r_dv_den[j+1]  <= r_dv_den[j];
                r_dv_sat[j+1]  <= r_dv_sat[j];
                r_dv_done[j+1] <= r_dv_done[j];
                r_dv_st[j+1]   <= r_dv_st[j];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_dv_v[CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            priority if (r_dv_done[CW]) begin
                r_out_item.contact_time   <= '0;
                r_out_item.contact_status <= r_dv_st[CW];
            end else if (r_dv_sat[CW]) begin
                r_out_item.contact_time   <= '1;
                r_out_item.contact_status <= dpct_pkg::ST_TIME;
            end else begin
                r_out_item.contact_time   <= r_dv_quo[CW];
                r_out_item.contact_status <= dpct_pkg::ST_TIME;
            end
        end
    end

    `ASSERT_IMPLY(a_time_only_when_ok, i_clk, i_rst_n, r_out_valid && (r_out_item.contact_status != dpct_pkg::ST_TIME), r_out_item.contact_time == '0)
    `ASSERT_IMPLY(a_stall_only_when_full, i_clk, i_rst_n, !o_in_ready, r_out_valid && !i_out_ready)
    `ASSERT_NEXT(a_pipe_holds_on_stall, i_clk, i_rst_n, !w_en, $stable(r_dv_quo[CW]) && $stable(r_dv_v[CW]) && $stable(r_sq_root[RTW]))
    `ASSERT_NEXT(a_saturate_to_max, i_clk, i_rst_n, w_en && r_dv_v[CW] && r_dv_sat[CW] && !r_dv_done[CW], r_out_item.contact_time == '1)

endmodule
